[design/cps_pkg.sv]
// ----------------------------------------------------------------------------
// cps_pkg
// Shared types and register indexes for the closest point on segment block.
// ----------------------------------------------------------------------------
package cps_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_END_A_X = 2'd0,
        REG_END_A_Y = 2'd1,
        REG_END_B_X = 2'd2,
        REG_END_B_Y = 2'd3
    } cfg_reg_t;

    // endpoint choice flags carried alongside the divide
    typedef struct packed {
        logic a_closer;
        logic degenerate;
    } sel_t;

endpackage

[design/cps_ifs.sv]
// ----------------------------------------------------------------------------
// cps_ifs
// Valid/ready channels for query points and results.
// ----------------------------------------------------------------------------
interface cps_pt_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] point_x;
    logic signed [W-1:0] point_y;

    modport source (output valid, output point_x, output point_y, input ready);
    modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

interface cps_res_if #(parameter int W = 16);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] near_x;
    logic signed [W-1:0] near_y;
    logic        [W:0]   distance;
    logic                on_interior;

    modport source (output valid, output near_x, output near_y, output distance,
                    output on_interior, input ready);
    modport sink   (input valid, input near_x, input near_y, input distance,
                    input on_interior, output ready);
endinterface

[design/cps_delay.sv]
// ----------------------------------------------------------------------------
// cps_delay
// Enabled shift line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module cps_delay #(
    parameter int WD = 8,
    parameter int D  = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic [WD-1:0] din,
    output logic [WD-1:0] dout
);

    logic [WD-1:0] tap_reg [D];

    // shift on every enabled cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < D; i++)
            begin
                tap_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < D; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[D-1];

endmodule

[design/cps_div.sv]
// ----------------------------------------------------------------------------
// cps_div
// Pipelined restoring divider, one quotient bit per stage, round half away.
// ----------------------------------------------------------------------------
module cps_div #(
    parameter int NW   = 52,
    parameter int DENW = 34,
    parameter int QB   = 19
) (
    input  logic                clk,
    input  logic                en,
    input  logic signed [NW-1:0] num,
    input  logic [DENW-1:0]     den,
    output logic signed [QB:0]  quo
);

    logic [NW-1:0]   rem_reg [QB+1];
    logic [DENW-1:0] den_reg [QB+1];
    logic            neg_reg [QB+1];
    logic [QB-1:0]   q_reg   [QB+1];
    logic signed [QB:0] quo_reg;

    // sign and magnitude
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num[NW-1] ? NW'(-num) : NW'(num);
            den_reg[0] <= den;
            neg_reg[0] <= num[NW-1];
            q_reg[0]   <= '0;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 1; k <= QB; k++)
    begin : g_step
        logic [NW-1:0] trial;
        logic          take;

        always_comb
        begin
            trial = NW'(den_reg[k-1]) << (QB - k);
            take  = rem_reg[k-1] >= trial;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= take ? rem_reg[k-1] - trial : rem_reg[k-1];
                den_reg[k] <= den_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                q_reg[k]   <= q_reg[k-1] | (take ? (QB'(1) << (QB - k)) : '0);
            end
        end
    end

    // round to nearest on the remainder, restore the sign
    logic [QB:0] qmag;
    always_comb
    begin
        qmag = {1'b0, q_reg[QB]}
             + (({rem_reg[QB], 1'b0} >= (NW+1)'(den_reg[QB])) ? (QB+1)'(1) : '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= neg_reg[QB] ? -$signed(qmag) : $signed(qmag);
        end
    end

    assign quo = quo_reg;

endmodule

[design/cps_isqrt.sv]
// ----------------------------------------------------------------------------
// cps_isqrt
// Pipelined floor integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module cps_isqrt #(
    parameter int NB = 17
) (
    input  logic            clk,
    input  logic            en,
    input  logic [2*NB-1:0] rad,
    output logic [NB-1:0]   root
);

    logic [2*NB-1:0] v_reg   [NB+1];
    logic [2*NB-1:0] res_reg [NB+1];

    // launch
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg[0]   <= rad;
            res_reg[0] <= '0;
        end
    end

    // digit-by-digit steps, bit weight falls by a factor of four each stage
    for (genvar k = 1; k <= NB; k++)
    begin : g_step
        logic [2*NB:0] trial;
        logic          take;

        always_comb
        begin
            trial = (2*NB+1)'(res_reg[k-1]) + ((2*NB+1)'(1) << (2 * (NB - k)));
            take  = (2*NB+1)'(v_reg[k-1]) >= trial;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[k]   <= take ? v_reg[k-1] - trial[2*NB-1:0] : v_reg[k-1];
                res_reg[k] <= take ? (res_reg[k-1] >> 1) + ((2*NB)'(1) << (2 * (NB - k)))
                                   : res_reg[k-1] >> 1;
            end
        end
    end

    assign root = res_reg[NB][NB-1:0];

endmodule

[design/closest_point_on_segment.sv]
// Closest point on segment A-B to each query point, with the Euclidean distance.
// Fully pipelined: one point per cycle sustained. Most of the pipeline is the
// bit-per-stage divider (COORD_BITS+5 registers) and the bit-per-stage square
// root (COORD_BITS+2 registers); the rest is five front stages, the select
// stage and three distance stages. The whole pipeline advances together; it
// holds while a result waits untaken.
// Endpoints are to be written through the cfg port only while no point is in
// flight; the user is bound to this, the block itself does not enforce it.
// ----------------------------------------------------------------------------
// closest_point_on_segment
// Top level: projection, endpoint choice and distance pipeline.
// ----------------------------------------------------------------------------
module closest_point_on_segment
    import cps_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_addr,
    input  logic [COORD_BITS-1:0] cfg_wdata,
    cps_pt_if.sink                pt,
    cps_res_if.source             res
);

    localparam int W   = COORD_BITS;
    localparam int SW  = W + 1;
    localparam int PW  = 2 * W + 2;
    localparam int DW  = 2 * W + 3;
    localparam int LOB = W + 2;
    localparam int HW  = DW - LOB;
    localparam int PLW = SW + LOB + 1;
    localparam int PHW = SW + HW;
    localparam int MW  = 3 * W + 4;
    localparam int QB  = W + 3;
    localparam int QW  = QB + 1;
    localparam int BW  = W + 5;
    localparam int NB  = W + 1;
    localparam int DL  = QB + 2;
    localparam int SB  = 6 + DL;
    localparam int F   = SB + 4 + NB;

    // configuration registers
    logic signed [W-1:0] ax_reg, ay_reg, bx_reg, by_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ax_reg <= '0;
            ay_reg <= '0;
            bx_reg <= '0;
            by_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_END_A_X: ax_reg <= cfg_wdata;
                REG_END_A_Y: ay_reg <= cfg_wdata;
                REG_END_B_X: bx_reg <= cfg_wdata;
                REG_END_B_Y: by_reg <= cfg_wdata;
                default:     ax_reg <= ax_reg;
            endcase
        end
    end

    // global advance and valid chain
    logic         en;
    logic [F-1:0] vld_reg;

    assign en       = !vld_reg[F-1] || res.ready;
    assign pt.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[F-2:0], pt.valid};
        end
    end

    // stage 1: differences
    logic signed [W-1:0]  px1_reg, py1_reg;
    logic signed [SW-1:0] sgx_reg, sgy_reg, vx_reg, vy_reg, wx_reg, wy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px1_reg <= pt.point_x;
            py1_reg <= pt.point_y;
            sgx_reg <= SW'(bx_reg) - SW'(ax_reg);
            sgy_reg <= SW'(by_reg) - SW'(ay_reg);
            vx_reg  <= SW'(pt.point_x) - SW'(ax_reg);
            vy_reg  <= SW'(pt.point_y) - SW'(ay_reg);
            wx_reg  <= SW'(pt.point_x) - SW'(bx_reg);
            wy_reg  <= SW'(pt.point_y) - SW'(by_reg);
        end
    end

    // stage 2: products
    logic signed [PW-1:0] lxx_reg, lyy_reg, dxx_reg, dyy_reg;
    logic signed [PW-1:0] axx_reg, ayy_reg, bxx_reg, byy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lxx_reg <= PW'(sgx_reg) * PW'(sgx_reg);
            lyy_reg <= PW'(sgy_reg) * PW'(sgy_reg);
            dxx_reg <= PW'(sgx_reg) * PW'(vx_reg);
            dyy_reg <= PW'(sgy_reg) * PW'(vy_reg);
            axx_reg <= PW'(vx_reg) * PW'(vx_reg);
            ayy_reg <= PW'(vy_reg) * PW'(vy_reg);
            bxx_reg <= PW'(wx_reg) * PW'(wx_reg);
            byy_reg <= PW'(wy_reg) * PW'(wy_reg);
        end
    end

    // stage 3: sums
    logic [PW-1:0]        len3_reg, da3_reg, db3_reg;
    logic signed [DW-1:0] dot3_reg;
    logic signed [SW-1:0] sgx3_reg, sgy3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len3_reg <= $unsigned(lxx_reg + lyy_reg);
            da3_reg  <= $unsigned(axx_reg + ayy_reg);
            db3_reg  <= $unsigned(bxx_reg + byy_reg);
            dot3_reg <= DW'(dxx_reg) + DW'(dyy_reg);
            sgx3_reg <= sgx_reg;
            sgy3_reg <= sgy_reg;
        end
    end

    // stage 4: split numerator products, endpoint flags
    logic signed [PLW-1:0] plx_reg, ply_reg;
    logic signed [PHW-1:0] phx_reg, phy_reg;
    logic [PW-1:0]         len4_reg;
    sel_t                  sel4_reg;
    logic signed [LOB:0]   dot_lo;
    logic signed [HW-1:0]  dot_hi;

    assign dot_lo = $signed({1'b0, dot3_reg[LOB-1:0]});
    assign dot_hi = dot3_reg[DW-1:LOB];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            plx_reg             <= PLW'(sgx3_reg) * PLW'(dot_lo);
            ply_reg             <= PLW'(sgy3_reg) * PLW'(dot_lo);
            phx_reg             <= PHW'(sgx3_reg) * PHW'(dot_hi);
            phy_reg             <= PHW'(sgy3_reg) * PHW'(dot_hi);
            len4_reg            <= len3_reg;
            sel4_reg.a_closer   <= da3_reg < db3_reg;
            sel4_reg.degenerate <= len3_reg == '0;
        end
    end

    // stage 5: full numerators
    logic signed [MW-1:0] mx_reg, my_reg;
    logic [PW-1:0]        len5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_reg   <= (MW'(phx_reg) <<< LOB) + MW'(plx_reg);
            my_reg   <= (MW'(phy_reg) <<< LOB) + MW'(ply_reg);
            len5_reg <= len4_reg;
        end
    end

    // projection offsets
    logic signed [QW-1:0] qx, qy;

    cps_div #(.NW(MW), .DENW(PW), .QB(QB)) u_div_x (
        .clk (clk), .en (en), .num (mx_reg), .den (len5_reg), .quo (qx)
    );

    cps_div #(.NW(MW), .DENW(PW), .QB(QB)) u_div_y (
        .clk (clk), .en (en), .num (my_reg), .den (len5_reg), .quo (qy)
    );

    // side data to the select stage
    sel_t                sel_d;
    logic signed [W-1:0] px_d, py_d;

    cps_delay #(.WD($bits(sel_t)), .D(SB - 5)) u_dly_sel (
        .clk (clk), .rst_n (rst_n), .en (en), .din (sel4_reg), .dout (sel_d)
    );

    cps_delay #(.WD(2 * W), .D(SB - 1)) u_dly_pt (
        .clk (clk), .rst_n (rst_n), .en (en),
        .din ({px1_reg, py1_reg}), .dout ({px_d, py_d})
    );

    // select stage: box test and endpoint fallback
    logic signed [BW-1:0] qxw, qyw, lox, hix, loy, hiy;
    logic                 inbox;
    logic signed [W-1:0]  nx_next, ny_next, nx_reg, ny_reg;
    logic                 int_next, int_reg;

    always_comb
    begin
        qxw   = BW'(ax_reg) + BW'(qx);
        qyw   = BW'(ay_reg) + BW'(qy);
        lox   = (ax_reg < bx_reg) ? BW'(ax_reg) : BW'(bx_reg);
        hix   = (ax_reg < bx_reg) ? BW'(bx_reg) : BW'(ax_reg);
        loy   = (ay_reg < by_reg) ? BW'(ay_reg) : BW'(by_reg);
        hiy   = (ay_reg < by_reg) ? BW'(by_reg) : BW'(ay_reg);
        inbox = (qxw >= lox) && (qxw <= hix) && (qyw >= loy) && (qyw <= hiy);
        int_next = 1'b0;
        if (sel_d.degenerate)
        begin
            nx_next = ax_reg;
            ny_next = ay_reg;
        end
        else if (inbox)
        begin
            nx_next  = qxw[W-1:0];
            ny_next  = qyw[W-1:0];
            int_next = 1'b1;
        end
        else if (sel_d.a_closer)
        begin
            nx_next = ax_reg;
            ny_next = ay_reg;
        end
        else
        begin
            nx_next = bx_reg;
            ny_next = by_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg  <= nx_next;
            ny_reg  <= ny_next;
            int_reg <= int_next;
        end
    end

    // distance: differences, squares, sum
    logic signed [SW-1:0] ex_reg, ey_reg;
    logic signed [PW-1:0] exx_reg, eyy_reg;
    logic [PW-1:0]        e2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ex_reg  <= SW'(px_d) - SW'(nx_reg);
            ey_reg  <= SW'(py_d) - SW'(ny_reg);
            exx_reg <= PW'(ex_reg) * PW'(ex_reg);
            eyy_reg <= PW'(ey_reg) * PW'(ey_reg);
            e2_reg  <= $unsigned(exx_reg + eyy_reg);
        end
    end

    cps_isqrt #(.NB(NB)) u_isqrt (
        .clk (clk), .en (en), .rad (e2_reg), .root (res.distance)
    );

    // closest point rides alongside the root
    cps_delay #(.WD(2 * W + 1), .D(F - SB)) u_dly_near (
        .clk (clk), .rst_n (rst_n), .en (en),
        .din ({nx_reg, ny_reg, int_reg}),
        .dout ({res.near_x, res.near_y, res.on_interior})
    );

    assign res.valid = vld_reg[F-1];

    // accepted transfer enters the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        pt.valid && pt.ready |=> vld_reg[0])
        else $error("accepted point not in first stage");

    // a held pipeline keeps every valid bit
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("valid chain moved while stalled");

    // last inner stage reaches the output on advance
    a_reach: assert property (@(posedge clk) disable iff (!rst_n)
        en && vld_reg[F-2] |=> res.valid)
        else $error("item lost before output");

endmodule

[bench/tb_closest_point_on_segment.sv]
// ----------------------------------------------------------------------------
// tb_closest_point_on_segment
// Self-checking bench for the closest point on segment block. Endpoints are
// programmed through the cfg port in several phases; query points are driven
// over the valid/ready channel with random gaps and results are compared,
// field by field, against a local projection and square-root predictor.
// ----------------------------------------------------------------------------
module tb_closest_point_on_segment;
    import cps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB      = 16;
    localparam int LATENCY = 16 + 2 * CB;
    localparam int WD_LIMIT = 20000;

    typedef struct packed {
        logic signed [CB-1:0] px;
        logic signed [CB-1:0] py;
    } query_t;

    typedef struct packed {
        logic signed [CB-1:0] nx;
        logic signed [CB-1:0] ny;
        logic [CB:0]          span;
        logic                 interior;
    } answer_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_addr;
    logic [CB-1:0] cfg_wdata;

    cps_pt_if  #(.W(CB)) pt ();
    cps_res_if #(.W(CB)) res ();

    closest_point_on_segment #(.COORD_BITS(CB)) DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata), .pt(pt.sink), .res(res.source)
    );

    // endpoint copy used by the predictor
    logic signed [CB-1:0] seg_ax, seg_ay, seg_bx, seg_by;

    query_t  point_queue[$];
    answer_t answer_queue[$];
    int n_sent, n_checked, n_mism, n_interior, n_endpoint, idle_cycles;
    bit done_driving, hold_rx, timed_out;

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // rounded quotient, ties away from zero
    function automatic longint round_quot(longint num, longint den);
        longint m, q, r;
        m = num < 0 ? -num : num;
        q = m / den;
        r = m % den;
        if (r >= den - r) q++;
        return num < 0 ? -q : q;
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r;
        r = 0;
        for (int b = 20; b >= 0; b--)
            if ((r + (64'sd1 << b)) * (r + (64'sd1 << b)) <= v) r += 64'sd1 << b;
        return r;
    endfunction

    function automatic answer_t project_point(query_t q);
        longint ax, ay, bx, by, px, py, sx, sy, len2, dp, qx, qy, nx, ny;
        longint da, db;
        answer_t a;
        ax = seg_ax; ay = seg_ay; bx = seg_bx; by = seg_by;
        px = q.px; py = q.py;
        sx = bx - ax; sy = by - ay;
        len2 = sx * sx + sy * sy;
        a.interior = 1'b0;
        nx = ax; ny = ay;
        if (len2 != 0) begin
            dp = sx * (px - ax) + sy * (py - ay);
            qx = ax + round_quot(sx * dp, len2);
            qy = ay + round_quot(sy * dp, len2);
            if (qx >= (ax < bx ? ax : bx) && qx <= (ax < bx ? bx : ax) &&
                qy >= (ay < by ? ay : by) && qy <= (ay < by ? by : ay))
            begin
                nx = qx; ny = qy; a.interior = 1'b1;
            end
            else
            begin
                da = (px - ax) * (px - ax) + (py - ay) * (py - ay);
                db = (px - bx) * (px - bx) + (py - by) * (py - by);
                if (da >= db)
                begin
                    nx = bx; ny = by;
                end
            end
        end
        a.nx = nx[CB-1:0];
        a.ny = ny[CB-1:0];
        a.span = (CB+1)'(int_sqrt((px - nx) * (px - nx) + (py - ny) * (py - ny)));
        return a;
    endfunction

    // driver
    int tx_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt.valid <= 1'b0;
            pt.point_x <= '0;
            pt.point_y <= '0;
            tx_gap = 0;
        end
        else
        begin
            if (pt.valid && pt.ready)
            begin
                answer_queue.push_back(project_point({pt.point_x, pt.point_y}));
                n_sent++;
                tx_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
            end
            if (!(pt.valid && !pt.ready))
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    pt.valid <= 1'b0;
                end
                else if (point_queue.size() > 0)
                begin
                    query_t q;
                    q = point_queue.pop_front();
                    pt.valid <= 1'b1;
                    pt.point_x <= q.px;
                    pt.point_y <= q.py;
                end
                else
                    pt.valid <= 1'b0;
            end
        end
    end

    // monitor and checker
    int rx_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res.ready <= 1'b0;
            rx_gap = 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                answer_t e;
                n_checked++;
                if (answer_queue.size() == 0)
                begin
                    n_mism++;
                    if (n_mism <= 10) $display("unexpected result %0d", n_checked);
                end
                else
                begin
                    e = answer_queue.pop_front();
                    if (e.interior) n_interior++; else n_endpoint++;
                    if (res.near_x !== e.nx || res.near_y !== e.ny ||
                        res.distance !== e.span || res.on_interior !== e.interior)
                    begin
                        n_mism++;
                        if (n_mism <= 10)
                            $display("mismatch #%0d exp (%0d,%0d) d=%0d i=%0d got (%0d,%0d) d=%0d i=%0d",
                                n_checked, e.nx, e.ny, e.span, e.interior,
                                res.near_x, res.near_y, res.distance, res.on_interior);
                    end
                end
                rx_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
            end
            if (hold_rx)
                res.ready <= 1'b0;
            else if (rx_gap > 0)
            begin
                rx_gap--;
                res.ready <= 1'b0;
            end
            else
                res.ready <= 1'b1;
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge clk)
    begin
        if ((pt.valid && pt.ready) || (res.valid && res.ready) || hold_rx)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WD_LIMIT)
        begin
            $display("watchdog expired");
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [CB-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_END_A_X: seg_ax = val;
            REG_END_A_Y: seg_ay = val;
            REG_END_B_X: seg_bx = val;
            default:     seg_by = val;
        endcase
    endtask

    task automatic set_segment(logic [CB-1:0] ax, logic [CB-1:0] ay,
                               logic [CB-1:0] bx, logic [CB-1:0] by);
        write_reg(REG_END_A_X, ax);
        write_reg(REG_END_A_Y, ay);
        write_reg(REG_END_B_X, bx);
        write_reg(REG_END_B_Y, by);
    endtask

    // wait until every queued point has gone and every result is back
    task automatic drain();
        while (point_queue.size() > 0 || pt.valid || answer_queue.size() > 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [CB-1:0] rand_coord(logic [CB-1:0] near);
        case ($urandom_range(0, 3))
            0: return CB'($urandom);
            1: return near + CB'($urandom_range(0, 64)) - CB'(32);
            2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            default: return CB'($urandom_range(0, 2047) - 1024);
        endcase
    endfunction

    task automatic add_random(int n);
        query_t q;
        for (int i = 0; i < n; i++)
        begin
            q.px = rand_coord(seg_ax);
            q.py = rand_coord(seg_by);
            point_queue.push_back(q);
        end
    endtask

    // stimulus
    initial
    begin
        query_t q;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        seg_ax = '0; seg_ay = '0; seg_bx = '0; seg_by = '0;
        hold_rx = 1'b0;
        idle_cycles = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // zero-length segment at reset values
        point_queue.push_back({16'sd100, -16'sd50});
        point_queue.push_back({16'sh7fff, 16'sh8000});
        drain();

        // directed: extremes, first endpoint, tie between endpoints
        set_segment(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
        point_queue.push_back({16'sh8000, 16'sh8000});
        point_queue.push_back({16'sh7fff, 16'sh7fff});
        point_queue.push_back({16'sh8000, 16'sh7fff});
        point_queue.push_back({16'sh7fff, 16'sh8000});
        point_queue.push_back({16'sd0, 16'sd0});
        point_queue.push_back({16'shffff, 16'sh0000});
        drain();
        set_segment(16'd0, 16'd0, 16'd160, 16'd0);
        point_queue.push_back({16'sd0, 16'sd0});
        point_queue.push_back({16'sd80, 16'sd300});
        point_queue.push_back({-16'sd40, 16'sd5});
        point_queue.push_back({16'sd200, -16'sd5});
        point_queue.push_back({16'sd80, 16'sh8000});
        drain();
        // tie: point on the bisector beyond a vertical segment's line
        set_segment(16'd0, -16'd16, 16'd0, 16'd16);
        point_queue.push_back({16'sd100, 16'sd0});
        point_queue.push_back({16'sd0, 16'sd0});
        point_queue.push_back({16'sd0, 16'sd300});
        drain();

        // random phases, endpoints set anew each phase, long receiver hold in one
        for (int ph = 0; ph < 14; ph++)
        begin
            case (ph % 4)
                0: set_segment(CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom));
                1: set_segment(CB'($urandom_range(0, 4095) - 2048),
                               CB'($urandom_range(0, 4095) - 2048),
                               CB'($urandom_range(0, 4095) - 2048),
                               CB'($urandom_range(0, 4095) - 2048));
                2: set_segment(16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
                default:
                begin
                    q.px = CB'($urandom);
                    q.py = CB'($urandom);
                    set_segment(q.px, q.py, q.px, q.py + CB'($urandom_range(0, 1)));
                end
            endcase
            add_random(125);
            if (ph == 3)
            begin
                hold_rx = 1'b1;
                repeat (300) @(posedge clk);
                hold_rx = 1'b0;
            end
            drain();
        end

        $display("covered %0d points, %0d interior and %0d endpoint results",
                 n_sent, n_interior, n_endpoint);
        $display("segment settings included zero length, full range and short segments");
        if (n_mism == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[sim.f]
design/cps_pkg.sv
design/cps_ifs.sv
design/cps_delay.sv
design/cps_div.sv
design/cps_isqrt.sv
design/closest_point_on_segment.sv
bench/tb_closest_point_on_segment.sv
